/* rtl/slt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Sentence lock table package
// Shared sizes, status and request codes, and controller/datapath bundles.
// ----------------------------------------------------------------------------
package slt_pkg;

  localparam int Files      = 4;
  localparam int Locks      = 16;
  localparam int Entries    = Files * Locks;
  localparam int FileW      = 2;
  localparam int LockW      = $clog2(Locks);
  localparam int EntryW     = $clog2(Entries);
  localparam int SessW      = 16;
  localparam int SentW      = 16;
  localparam int TimeW      = 32;
  localparam int StatusW    = 3;

  localparam logic [1:0] KIND_ACQUIRE     = 2'd0;
  localparam logic [1:0] KIND_RELEASE     = 2'd1;
  localparam logic [1:0] KIND_RELEASE_ALL = 2'd2;
  localparam logic [1:0] KIND_CLEANUP     = 2'd3;

  localparam logic [StatusW-1:0] ST_OK       = 3'd0;
  localparam logic [StatusW-1:0] ST_BAD      = 3'd1;
  localparam logic [StatusW-1:0] ST_LOCKED   = 3'd2;
  localparam logic [StatusW-1:0] ST_FULL     = 3'd3;
  localparam logic [StatusW-1:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic              load;
    logic              scan;
    logic [EntryW-1:0] idx;
    logic              commit;
  } cmd_t;

  typedef struct packed {
    logic               done;
    logic [StatusW-1:0] status;
    logic [SessW-1:0]   granted;
  } stat_t;

endpackage

`default_nettype wire

/* rtl/slt_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module slt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output      logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/slt_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Lock table datapath
// Entry storage, valid bits, session counters and the per-entry scan checks.
// ----------------------------------------------------------------------------
module slt_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire slt_pkg::cmd_t               cmd,
  input  wire logic [1:0]                  kind,
  input  wire logic [slt_pkg::FileW-1:0]   file_slot,
  input  wire logic [slt_pkg::SentW-1:0]   sentence_num,
  input  wire logic [slt_pkg::SessW-1:0]   session_num,
  input  wire logic [slt_pkg::TimeW-1:0]   now_seconds,
  input  wire logic [slt_pkg::TimeW-1:0]   stale_cutoff,
  output      slt_pkg::stat_t              stat
);

  localparam int EW = slt_pkg::EntryW;
  localparam int LW = slt_pkg::LockW;
  localparam int DW = slt_pkg::SentW + slt_pkg::SessW + slt_pkg::TimeW;

  logic [1:0]                  r_kind;
  logic [slt_pkg::FileW-1:0]   r_file;
  logic [slt_pkg::SentW-1:0]   r_sent;
  logic [slt_pkg::SessW-1:0]   r_sess;
  logic [slt_pkg::TimeW-1:0]   r_now;
  logic [slt_pkg::Entries-1:0] valid;
  logic [slt_pkg::SessW-1:0]   next_session [slt_pkg::Files];
  logic                        hit;
  logic                        free_found;
  logic [LW-1:0]               free_idx;

  logic          chk;
  logic [EW-1:0] chk_idx;

  logic          we;
  logic [EW-1:0] waddr;
  logic [DW-1:0] wdata;
  logic [DW-1:0] rdata;
  logic [slt_pkg::SessW-1:0] sess_id;

  slt_ram #(.Width(DW), .Depth(slt_pkg::Entries)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (cmd.idx),
    .rdata (rdata)
  );

  logic [slt_pkg::SentW-1:0] e_sent;
  logic [slt_pkg::SessW-1:0] e_sess;
  logic [slt_pkg::TimeW-1:0] e_time;
  logic                      e_valid;
  logic [slt_pkg::TimeW:0]   age;
  logic                      stale;

  assign e_sent  = rdata[DW-1 -: slt_pkg::SentW];
  assign e_sess  = rdata[slt_pkg::TimeW +: slt_pkg::SessW];
  assign e_time  = rdata[slt_pkg::TimeW-1:0];
  assign e_valid = valid[chk_idx];
  assign age     = {1'b0, r_now} - {1'b0, e_time};
  assign stale   = !age[slt_pkg::TimeW] && (age[slt_pkg::TimeW-1:0] > stale_cutoff);

  always_comb begin
    sess_id = next_session[r_file];
    if (sess_id == '0) begin
      sess_id = slt_pkg::SessW'(1);
    end
  end

  assign we    = cmd.commit && (r_kind == slt_pkg::KIND_ACQUIRE) && (r_sent != '0)
                 && !hit && free_found;
  assign waddr = {r_file, free_idx};
  assign wdata = {r_sent, sess_id, r_now};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      chk   <= 1'b0;
      for (int f = 0; f < slt_pkg::Files; f++) begin
        next_session[f] <= slt_pkg::SessW'(1);
      end
    end else begin
      chk     <= cmd.scan;
      chk_idx <= cmd.idx;
      if (cmd.load) begin
        r_kind     <= kind;
        r_file     <= file_slot;
        r_sent     <= sentence_num;
        r_sess     <= session_num;
        r_now      <= now_seconds;
        hit        <= 1'b0;
        free_found <= 1'b0;
        free_idx   <= '0;
      end
      if (chk && e_valid) begin
        unique case (r_kind)
          slt_pkg::KIND_ACQUIRE: begin
            if (e_sent == r_sent) hit <= 1'b1;
          end
          slt_pkg::KIND_RELEASE: begin
            if (!hit && e_sent == r_sent && e_sess == r_sess) begin
              hit            <= 1'b1;
              valid[chk_idx] <= 1'b0;
            end
          end
          slt_pkg::KIND_RELEASE_ALL: begin
            if (e_sess == r_sess) valid[chk_idx] <= 1'b0;
          end
          slt_pkg::KIND_CLEANUP: begin
            if (stale_cutoff != '0 && stale) valid[chk_idx] <= 1'b0;
          end
          default: ;
        endcase
      end else if (chk && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= chk_idx[LW-1:0];
      end
      if (we) begin
        valid[waddr]         <= 1'b1;
        next_session[r_file] <= sess_id + slt_pkg::SessW'(1);
      end
    end
  end

  always_comb begin
    stat.done    = cmd.commit;
    stat.granted = '0;
    stat.status  = slt_pkg::ST_OK;
    unique case (r_kind)
      slt_pkg::KIND_ACQUIRE: begin
        if (r_sent == '0)     stat.status = slt_pkg::ST_BAD;
        else if (hit)         stat.status = slt_pkg::ST_LOCKED;
        else if (!free_found) stat.status = slt_pkg::ST_FULL;
        else                  stat.granted = sess_id;
      end
      slt_pkg::KIND_RELEASE: begin
        if (r_sent == '0 || r_sess == '0) stat.status = slt_pkg::ST_BAD;
        else if (!hit)                    stat.status = slt_pkg::ST_NOTFOUND;
      end
      slt_pkg::KIND_RELEASE_ALL: begin
        if (r_sess == '0) stat.status = slt_pkg::ST_BAD;
      end
      default: stat.status = slt_pkg::ST_OK;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/slt_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Lock table controller
// Sequences the scan of one file's table, or all tables for cleanup.
// ----------------------------------------------------------------------------
module slt_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output      logic                      in_stall,
  input  wire logic [1:0]                kind,
  input  wire logic [slt_pkg::FileW-1:0] file_slot,
  output      slt_pkg::cmd_t             cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_TAIL = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam int EW = slt_pkg::EntryW;
  localparam int LW = slt_pkg::LockW;

  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [EW-1:0] idx;
  logic [EW-1:0] last;
  logic          accept;

  // Single-slot pipeline: stall while a request is in flight.
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.scan   = 1'b0;
    cmd.commit = 1'b0;
    cmd.idx    = idx;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (idx == last) state_next = S_TAIL;
      end
      S_TAIL: state_next = S_DONE;
      S_DONE: begin
        cmd.commit = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      last  <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (kind == slt_pkg::KIND_CLEANUP) begin
          idx  <= '0;
          last <= EW'(slt_pkg::Entries - 1);
        end else begin
          idx  <= {file_slot, LW'(0)};
          last <= {file_slot, {LW{1'b1}}};
        end
      end else if (state == S_SCAN && idx != last) begin
        idx <= idx + EW'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/sentence_lock_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Sentence lock table
// Per-file sentence lock tables with acquire, release, release-all, cleanup.
//
// Requests enter on the in channel (in_valid/in_stall) and each gives exactly
// one result on the out channel (out_valid/out_stall): status and the granted
// session id. One request is worked at a time. A file request scans that
// file's 16 entries through the entry RAM read port, one per cycle, and
// cleanup scans all 64 entries. After the scan the controller steps through
// its tail and done states, and the result is then registered into an
// output register, where it holds while out_stall is high. The block stalls
// its input while a request is in flight and while a result waits on a
// stalled output. Reset (rst, synchronous) clears every valid bit, sets each
// file's session counter to one and clears stale_cutoff. stale_cutoff_we
// writes the cutoff register.
// ----------------------------------------------------------------------------
module sentence_lock_table (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      stale_cutoff_we,
  input  wire logic [slt_pkg::TimeW-1:0] stale_cutoff_wdata,
  input  wire logic                      in_valid,
  output      logic                      in_stall,
  input  wire logic [1:0]                kind,
  input  wire logic [slt_pkg::FileW-1:0] file_slot,
  input  wire logic [slt_pkg::SentW-1:0] sentence_num,
  input  wire logic [slt_pkg::SessW-1:0] session_num,
  input  wire logic [slt_pkg::TimeW-1:0] now_seconds,
  output      logic                      out_valid,
  input  wire logic                      out_stall,
  output      logic [slt_pkg::StatusW-1:0] status,
  output      logic [slt_pkg::SessW-1:0]   granted_session
);

  logic [slt_pkg::TimeW-1:0] stale_cutoff;
  slt_pkg::cmd_t             cmd;
  slt_pkg::stat_t            stat;
  logic                      busy_stall;
  logic                      in_valid_gated;

  // Hold off new requests while an undelivered result still occupies the output.
  assign in_valid_gated = in_valid && !(out_valid && out_stall);
  assign in_stall       = busy_stall || (out_valid && out_stall);

  slt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid_gated),
    .in_stall  (busy_stall),
    .kind      (kind),
    .file_slot (file_slot),
    .cmd       (cmd)
  );

  slt_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .kind         (kind),
    .file_slot    (file_slot),
    .sentence_num (sentence_num),
    .session_num  (session_num),
    .now_seconds  (now_seconds),
    .stale_cutoff (stale_cutoff),
    .stat         (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stale_cutoff <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (stale_cutoff_we) stale_cutoff <= stale_cutoff_wdata;
      if (stat.done) begin
        out_valid       <= 1'b1;
        status          <= stat.status;
        granted_session <= stat.granted;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
